### hw/rtl/ptrs_pkg.sv
// ----------------------------------------------------------------------------
// ptrs_pkg
// Shared types for the periodic task release scheduler: operation codes,
// the decoded command that travels from front end to back end, and the
// result item.
// ----------------------------------------------------------------------------
package ptrs_pkg;

    localparam int OP_BITS   = 3;
    localparam int SLOT_BITS = 3;
    localparam int TIME_BITS = 16;
    localparam int MASK_BITS = 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK     = 3'd0,
        OP_CREATE   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_START    = 3'd3,
        OP_STOP     = 3'd4,
        OP_DISPATCH = 3'd5
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [SLOT_BITS-1:0] slot;
        logic                 in_range;
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] first_delay;
        logic                 start_paused;
    } cmd_t;

    typedef struct packed {
        logic                 released;
        logic [SLOT_BITS-1:0] released_slot;
        logic [MASK_BITS-1:0] ready_mask;
        logic                 slot_empty_error;
        logic                 last;
    } res_t;

endpackage

### hw/rtl/ptrs_fifo.sv
// ----------------------------------------------------------------------------
// ptrs_fifo
// Small register queue used between the front end and back end and as the
// result buffer. Push and pop must be qualified by full and empty.
// ----------------------------------------------------------------------------
module ptrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    store_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign rdata = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("transfer into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("transfer out of an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

### hw/rtl/ptrs_front.sv
// ----------------------------------------------------------------------------
// ptrs_front
// Input side: takes items from the push/full port, decodes the operation,
// range-checks the slot and hands a command to the command queue.
// ----------------------------------------------------------------------------
module ptrs_front #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                               push,
    output logic                               full,
    input  logic [ptrs_pkg::OP_BITS-1:0]       operation,
    input  logic [ptrs_pkg::SLOT_BITS-1:0]     slot,
    input  logic [ptrs_pkg::TIME_BITS-1:0]     period,
    input  logic [ptrs_pkg::TIME_BITS-1:0]     first_delay,
    input  logic                               start_paused,
    output logic                               cmd_push,
    output ptrs_pkg::cmd_t                     cmd,
    input  logic                               cmd_full
);
    import ptrs_pkg::*;

    localparam logic [5:0] SLOT_LIMIT = 6'(SLOT_COUNT);

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

    always_comb
    begin
        cmd.op           = op_t'(operation);
        cmd.slot         = slot;
        cmd.in_range     = ({3'b000, slot} < SLOT_LIMIT);
        cmd.period       = period;
        cmd.first_delay  = first_delay;
        cmd.start_paused = start_paused;
    end

endmodule

### hw/rtl/ptrs_back.sv
// ----------------------------------------------------------------------------
// ptrs_back
// Slot table and execution sequencer. Runs one command at a time; a tick
// updates all valid unpaused slots together, a dispatch releases one ready
// slot per cycle in index order while the result queue is not full.
// ----------------------------------------------------------------------------
module ptrs_back #(
    parameter int SLOT_COUNT = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ptrs_pkg::cmd_t cmd,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    output ptrs_pkg::res_t res,
    output logic           res_push,
    input  logic           res_full
);
    import ptrs_pkg::*;

    // the slot field is 3 bits wide, so only the first eight slots are reachable
    localparam int USED_SLOTS = (SLOT_COUNT < 8) ? SLOT_COUNT : 8;
    localparam int IDX_BITS   = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_DISP
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [USED_SLOTS-1:0]   valid_reg;
    logic [USED_SLOTS-1:0]   valid_next;
    logic [USED_SLOTS-1:0]   paused_reg;
    logic [USED_SLOTS-1:0]   paused_next;
    logic [USED_SLOTS-1:0]   ready_reg;
    logic [USED_SLOTS-1:0]   ready_next;
    logic [COUNT_BITS-1:0]   period_reg [USED_SLOTS];
    logic [COUNT_BITS-1:0]   period_next [USED_SLOTS];
    logic [COUNT_BITS-1:0]   count_reg [USED_SLOTS];
    logic [COUNT_BITS-1:0]   count_next [USED_SLOTS];

    logic [IDX_BITS-1:0]     idx;
    logic [IDX_BITS-1:0]     sel_idx;
    logic [USED_SLOTS-1:0]   sel_onehot;
    logic                    slot_err;

    assign idx      = cmd.slot[IDX_BITS-1:0];
    assign slot_err = !cmd.in_range || !valid_reg[idx];

    // lowest ready slot
    always_comb
    begin
        sel_idx    = '0;
        sel_onehot = '0;
        for (int k = USED_SLOTS - 1; k >= 0; k--)
        begin
            if (ready_reg[k])
            begin
                sel_idx    = IDX_BITS'(k);
                sel_onehot = '0;
                sel_onehot[k] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        paused_next = paused_reg;
        ready_next  = ready_reg;
        period_next = period_reg;
        count_next  = count_reg;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        res         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_TICK:
                        begin
                            for (int k = 0; k < USED_SLOTS; k++)
                            begin
                                if (valid_reg[k] && !paused_reg[k])
                                begin
                                    if (count_reg[k] == '0)
                                    begin
                                        ready_next[k] = 1'b1;
                                        count_next[k] = period_reg[k] - 1'b1;
                                    end
                                    else
                                    begin
                                        count_next[k] = count_reg[k] - 1'b1;
                                    end
                                end
                            end
                        end
                        OP_CREATE:
                        begin
                            if (cmd.in_range)
                            begin
                                valid_next[idx]  = 1'b1;
                                paused_next[idx] = cmd.start_paused;
                                ready_next[idx]  = 1'b0;
                                period_next[idx] = COUNT_BITS'(cmd.period);
                                count_next[idx]  = COUNT_BITS'(cmd.first_delay);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (cmd.in_range)
                            begin
                                valid_next[idx]  = 1'b0;
                                paused_next[idx] = 1'b0;
                                ready_next[idx]  = 1'b0;
                                period_next[idx] = '0;
                                count_next[idx]  = '0;
                            end
                        end
                        OP_START,
                        OP_STOP:
                        begin
                            if (!slot_err)
                            begin
                                paused_next[idx] = (cmd.op == OP_STOP);
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (cmd.op == OP_DISPATCH && ready_reg != '0)
                    begin
                        state_next = ST_DISP;
                    end
                    else
                    begin
                        res_push             = 1'b1;
                        res.ready_mask       = MASK_BITS'(ready_next);
                        res.slot_empty_error = (cmd.op == OP_START || cmd.op == OP_STOP)
                                               && slot_err;
                        res.last             = 1'b1;
                    end
                end
            end
            ST_DISP:
            begin
                if (!res_full)
                begin
                    res_push          = 1'b1;
                    res.released      = 1'b1;
                    res.released_slot = SLOT_BITS'(sel_idx);
                    // every ready slot is released by this dispatch, so the mask reported
                    // is the one after the whole dispatch, which is all clear
                    res.ready_mask    = '0;
                    res.last          = ((ready_reg & ~sel_onehot) == '0);
                    ready_next[sel_idx] = 1'b0;
                    if (period_reg[sel_idx] == '0)
                    begin
                        paused_next[sel_idx] = 1'b1;
                    end
                    if (res.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            paused_reg <= '0;
            ready_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            paused_reg <= paused_next;
            ready_reg  <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= period_next;
        count_reg  <= count_next;
    end

    a_disp_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISP) |-> (ready_reg != '0))
        else $error("dispatch running with no ready slot");

    a_ready_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_reg & ~valid_reg) == '0)
        else $error("empty slot marked ready");

    a_last_ends_disp: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.released && res.last) |=> (state_reg == ST_IDLE))
        else $error("dispatch did not finish after final release");

    a_no_pop_in_disp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISP) |-> !cmd_pop)
        else $error("command taken while dispatch in progress");

endmodule

### hw/rtl/periodic_task_release_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler
// Table of periodic task slots driven by tick/create/delete/start/stop/
// dispatch commands; dispatch releases ready slots in index order.
// ----------------------------------------------------------------------------
// Commands enter through a two-entry command queue and results leave through
// a two-entry result queue, so the input side keeps taking commands while
// results wait to be popped, until the command queue fills. The back-end
// sequencer executes one command at a time: tick, create, delete, start,
// stop, an unused code and a dispatch that finds nothing ready each give
// one result; a dispatch that releases N slots gives N results, one per
// cycle while the result queue has room. Without stalls a command is
// registered in the command queue and its first result in the result queue;
// a dispatch that releases slots goes through the dispatch state between.
// No clearing pass is needed after reset; the slot table is ready at once.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler #(
    parameter int SLOT_COUNT = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [ptrs_pkg::OP_BITS-1:0]       operation,
    input  logic [ptrs_pkg::SLOT_BITS-1:0]     slot,
    input  logic [ptrs_pkg::TIME_BITS-1:0]     period,
    input  logic [ptrs_pkg::TIME_BITS-1:0]     first_delay,
    input  logic                               start_paused,
    output logic                               empty,
    input  logic                               pop,
    output logic                               released,
    output logic [ptrs_pkg::SLOT_BITS-1:0]     released_slot,
    output logic [ptrs_pkg::MASK_BITS-1:0]     ready_mask,
    output logic                               slot_empty_error,
    output logic                               last
);
    import ptrs_pkg::*;

    localparam int CMD_WIDTH = $bits(cmd_t);
    localparam int RES_WIDTH = $bits(res_t);

    cmd_t  cmd_in;
    cmd_t  cmd_out;
    logic  cmd_push;
    logic  cmd_full;
    logic  cmd_pop;
    logic  cmd_empty;
    res_t  res_in;
    res_t  res_out;
    logic  res_push;
    logic  res_full;
    logic  res_pop;

    ptrs_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .push         (push),
        .full         (full),
        .operation    (operation),
        .slot         (slot),
        .period       (period),
        .first_delay  (first_delay),
        .start_paused (start_paused),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in),
        .cmd_full     (cmd_full)
    );

    ptrs_fifo #(
        .WIDTH (CMD_WIDTH),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    ptrs_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res_in),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    assign res_pop = pop && !empty;

    ptrs_fifo #(
        .WIDTH (RES_WIDTH),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (res_pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign released         = res_out.released;
    assign released_slot    = res_out.released_slot;
    assign ready_mask       = res_out.ready_mask;
    assign slot_empty_error = res_out.slot_empty_error;
    assign last             = res_out.last;

endmodule

### dv/periodic_task_release_scheduler_tb.sv
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_tb
// Self-checking bench for the periodic task release scheduler. A directed
// run covers empty-slot errors, one-shot and wrapping periods, overwrite on
// create and a dispatch that releases every slot. A random run follows,
// mostly short periods and delays so that slots fire often. Input and result
// transfers are watched at the clock edge; a slot-table model predicts every
// result and compares it field by field as it is popped.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ptrs_pkg::*;

    localparam int NUM_SLOTS    = 8;
    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_REPORTS  = 10;

    // codes the block has no operation for
    localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd7;

    class sched_scoreboard;
        bit                  valid[NUM_SLOTS];
        bit                  paused[NUM_SLOTS];
        bit                  ready[NUM_SLOTS];
        bit [TIME_BITS-1:0]  reload[NUM_SLOTS];
        bit [TIME_BITS-1:0]  count[NUM_SLOTS];
        res_t                release_q[$];
        int                  mismatch_count;

        function new();
            mismatch_count = 0;
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                valid[k]  = 1'b0;
                paused[k] = 1'b0;
                ready[k]  = 1'b0;
                reload[k] = '0;
                count[k]  = '0;
            end
        endfunction

        function int outstanding();
            return release_q.size();
        endfunction

        // Apply one accepted command to the slot table and queue its results.
        function void note_command(logic [OP_BITS-1:0] op, logic [SLOT_BITS-1:0] s,
                                   logic [TIME_BITS-1:0] per, logic [TIME_BITS-1:0] fd,
                                   logic sp);
            bit                  err;
            int                  n;
            int                  rel[NUM_SLOTS];
            bit [MASK_BITS-1:0]  mask;
            res_t                r;
            err = 1'b0;
            n = 0;
            case (op)
                OP_TICK:
                begin
                    for (int k = 0; k < NUM_SLOTS; k++)
                    begin
                        if (valid[k] && !paused[k])
                        begin
                            if (count[k] == 0)
                            begin
                                ready[k] = 1'b1;
                                count[k] = reload[k] - 1'b1;
                            end
                            else
                                count[k] = count[k] - 1'b1;
                        end
                    end
                end
                OP_CREATE:
                begin
                    if (s < NUM_SLOTS)
                    begin
                        valid[s]  = 1'b1;
                        paused[s] = sp;
                        ready[s]  = 1'b0;
                        reload[s] = per;
                        count[s]  = fd;
                    end
                end
                OP_DELETE:
                begin
                    if (s < NUM_SLOTS)
                    begin
                        valid[s]  = 1'b0;
                        paused[s] = 1'b0;
                        ready[s]  = 1'b0;
                        reload[s] = '0;
                        count[s]  = '0;
                    end
                end
                OP_START, OP_STOP:
                begin
                    if (s < NUM_SLOTS && valid[s])
                        paused[s] = (op == OP_STOP);
                    else
                        err = 1'b1;
                end
                OP_DISPATCH:
                begin
                    for (int k = 0; k < NUM_SLOTS && n < 8; k++)
                    begin
                        if (valid[k] && ready[k])
                        begin
                            rel[n] = k;
                            n++;
                            // period 0 is a one-shot
                            if (reload[k] == 0)
                                paused[k] = 1'b1;
                            ready[k] = 1'b0;
                        end
                    end
                end
                default: ;
            endcase

            mask = '0;
            for (int k = 0; k < NUM_SLOTS && k < MASK_BITS; k++)
                mask[k] = ready[k];

            if (n == 0)
            begin
                r.released         = 1'b0;
                r.released_slot    = '0;
                r.ready_mask       = mask;
                r.slot_empty_error = err;
                r.last             = 1'b1;
                release_q.push_back(r);
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    r.released         = 1'b1;
                    r.released_slot    = rel[i][SLOT_BITS-1:0];
                    r.ready_mask       = mask;
                    r.slot_empty_error = 1'b0;
                    r.last             = (i == n - 1);
                    release_q.push_back(r);
                end
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (release_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"%0t: result with nothing expected: ",
                              "rel=%0b slot=%0d mask=%02h err=%0b last=%0b"},
                             $realtime, got.released, got.released_slot, got.ready_mask,
                             got.slot_empty_error, got.last);
                return;
            end
            want = release_q.pop_front();
            if (got.released !== want.released ||
                got.released_slot !== want.released_slot ||
                got.ready_mask !== want.ready_mask ||
                got.slot_empty_error !== want.slot_empty_error ||
                got.last !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch exp rel=%0b slot=%0d mask=%02h err=%0b last=%0b",
                             $realtime, want.released, want.released_slot, want.ready_mask,
                             want.slot_empty_error, want.last);
                    $display("%0t:          got rel=%0b slot=%0d mask=%02h err=%0b last=%0b",
                             $realtime, got.released, got.released_slot, got.ready_mask,
                             got.slot_empty_error, got.last);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [OP_BITS-1:0]    operation = '0;
    logic [SLOT_BITS-1:0]  slot = '0;
    logic [TIME_BITS-1:0]  period = '0;
    logic [TIME_BITS-1:0]  first_delay = '0;
    logic                  start_paused = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  released;
    logic [SLOT_BITS-1:0]  released_slot;
    logic [MASK_BITS-1:0]  ready_mask;
    logic                  slot_empty_error;
    logic                  last;

    sched_scoreboard sb;

    int unsigned pop_mode = 0;
    int unsigned pop_mode_left = 0;
    int unsigned pop_phase = 0;

    periodic_task_release_scheduler uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .operation        (operation),
        .slot             (slot),
        .period           (period),
        .first_delay      (first_delay),
        .start_paused     (start_paused),
        .empty            (empty),
        .pop              (pop),
        .released         (released),
        .released_slot    (released_slot),
        .ready_mask       (ready_mask),
        .slot_empty_error (slot_empty_error),
        .last             (last)
    );

    always #5 clk = ~clk;

    // Transfer monitor: commands are noted before results are checked.
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (push && !full)
                sb.note_command(operation, slot, period, first_delay, start_paused);
            if (pop && !empty)
                sb.check_result('{released, released_slot, ready_mask,
                                  slot_empty_error, last});
        end
    end

    // Result side: switches between free-running, random, sparse and
    // periodic pop patterns.
    always @(posedge clk)
    begin
        pop_phase <= pop_phase + 1;
        if (pop_mode_left == 0)
        begin
            pop_mode      <= $urandom_range(0, 3);
            pop_mode_left <= $urandom_range(10, 150);
        end
        else
            pop_mode_left <= pop_mode_left - 1;
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (pop_phase % 3 == 0);
        endcase
    end

    // Holds the command on the ports until the transfer happens.
    task automatic drive_item(input logic [OP_BITS-1:0] op, input logic [SLOT_BITS-1:0] s,
                              input logic [TIME_BITS-1:0] per,
                              input logic [TIME_BITS-1:0] fd, input logic sp);
        push         <= 1'b1;
        operation    <= op;
        slot         <= s;
        period       <= per;
        first_delay  <= fd;
        start_paused <= sp;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic drive_random_item();
        int unsigned         pick;
        int unsigned         sel;
        logic [OP_BITS-1:0]  op;
        logic [TIME_BITS-1:0] per;
        logic [TIME_BITS-1:0] fd;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            op = OP_TICK;
        else if (pick < 50)
            op = OP_CREATE;
        else if (pick < 55)
            op = OP_DELETE;
        else if (pick < 63)
            op = OP_START;
        else if (pick < 71)
            op = OP_STOP;
        else if (pick < 96)
            op = OP_DISPATCH;
        else
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        // short periods and delays keep slots firing; full range now and then
        sel = $urandom_range(0, 9);
        if (sel < 7)
            per = TIME_BITS'($urandom_range(0, 4));
        else if (sel == 7)
            per = '0;
        else
            per = TIME_BITS'($urandom_range(0, 65535));
        sel = $urandom_range(0, 9);
        if (sel < 8)
            fd = TIME_BITS'($urandom_range(0, 3));
        else
            fd = TIME_BITS'($urandom_range(0, 65535));
        drive_item(op, SLOT_BITS'($urandom_range(0, NUM_SLOTS - 1)), per, fd,
                   1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int unsigned burst_left;
        sb = new();
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, errors, spare codes
        drive_item(OP_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_START, 3'd3, 16'hFFFF, 16'hFFFF, 1'b1);
        drive_item(OP_STOP, 3'd7, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_DISPATCH, 3'd0, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_SPARE_A, 3'd5, 16'hFFFF, 16'hFFFF, 1'b1);
        drive_item(OP_SPARE_B, 3'd2, 16'h1234, 16'h8000, 1'b0);
        // fill every slot: one-shot in slot 0, largest period in slot 7
        drive_item(OP_CREATE, 3'd0, 16'h0000, 16'h0000, 1'b0);
        for (int k = 1; k < NUM_SLOTS - 1; k++)
            drive_item(OP_CREATE, k[SLOT_BITS-1:0], k[TIME_BITS-1:0], 16'h0000, 1'b0);
        drive_item(OP_CREATE, 3'd7, 16'hFFFF, 16'h0000, 1'b0);
        drive_item(OP_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
        // all eight slots released in one dispatch
        drive_item(OP_DISPATCH, 3'd0, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_CREATE, 3'd5, 16'h0002, 16'h0000, 1'b1);
        drive_item(OP_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_START, 3'd5, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
        // overwrite a ready slot: its ready mark goes away
        drive_item(OP_CREATE, 3'd1, 16'h0003, 16'hFFFF, 1'b0);
        drive_item(OP_STOP, 3'd2, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_DELETE, 3'd4, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_DELETE, 3'd4, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_START, 3'd4, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_DISPATCH, 3'd0, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_START, 3'd0, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
        drive_item(OP_DISPATCH, 3'd0, 16'h0000, 16'h0000, 1'b0);

        // random bursts with random gaps, some bursts back to back
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    push <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            drive_random_item();
            burst_left--;
        end
        push <= 1'b0;

        // let the monitor note the final transfer before draining
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ptrs_pkg.sv
hw/rtl/ptrs_fifo.sv
hw/rtl/ptrs_front.sv
hw/rtl/ptrs_back.sv
hw/rtl/periodic_task_release_scheduler.sv
dv/periodic_task_release_scheduler_tb.sv
